### design/mm2p_pkg.sv
// Shared types and constants for the modular 2x2 matrix power block
package mm2p_pkg;

	// Field width of one matrix entry and the prime modulus
	localparam int unsigned EW = 30;

	typedef logic [EW-1:0] elem_t;

	localparam elem_t MOD_P = 30'd1000000007;

	// Barrett factor floor(2^60 / P) for entry products below 2^60
	localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

	// One 2x2 matrix, entries a b / c d
	typedef struct packed {
		elem_t a;
		elem_t b;
		elem_t c;
		elem_t d;
	} mat_t;

	// Tag carried alongside each product through the multiply-reduce pipe
	typedef struct packed {
		logic       vld;
		logic       sq;    // product belongs to the squaring of the base
		logic [1:0] ent;   // destination entry: a, b, c, d
		logic       term;  // second of the two products of that entry
	} op_tag_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_COMMIT,
		ST_DONE
	} state_t;

	// Add two residues and fold once into 0..P-1
	function automatic elem_t mod_add(elem_t x, elem_t y);
		logic [EW:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, MOD_P}) begin
			s = s - {1'b0, MOD_P};
		end
		return s[EW-1:0];
	endfunction

endpackage

### design/modular_matrix2x2_power.sv
// Channel  Dir  Width  Contents (low bit first)
// s_*      in   152    base_a, base_b, base_c, base_d (30 each), power (32)
// m_*      out  120    out_a, out_b, out_c, out_d (30 each)
//
// Each exponent bit issues 16 products in turn into the single five-stage
// multiply-reduce pipe, waits for it to drain and commits.
// s_tready is high only while idle; a finished result waits in the output
// register and a new word is accepted meanwhile.
// Reset is asynchronous and clears the sequencer and the output valid.
module modular_matrix2x2_power #(
	parameter int EXP_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [151:0] s_tdata,   // base_a, base_b, base_c, base_d, power
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata    // out_a, out_b, out_c, out_d
);

	localparam int CW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

	mm2p_pkg::state_t state_q, state_d;

	logic [3:0]          slot_q;
	logic [CW-1:0]       bit_q;
	logic [EXP_BITS-1:0] pow_q;
	logic                m_tvalid_q;
	logic [119:0]        out_q;

	mm2p_pkg::mat_t  base_q, acc_q, nbase_q, nacc_q, xm;
	mm2p_pkg::elem_t hold_q, pair_sum;
	mm2p_pkg::elem_t op_x, op_y, res;
	mm2p_pkg::op_tag_t tag_in, tag_out;

	logic accept, issue, out_load, last_bit, last_res;

	assign accept   = s_tvalid && s_tready;
	assign last_bit = (bit_q == CW'(EXP_BITS - 1));
	assign last_res = tag_out.vld && tag_out.sq && tag_out.term && (tag_out.ent == 2'd3);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mm2p_pkg::ST_IDLE: begin
				if (accept) state_d = mm2p_pkg::ST_ISSUE;
			end
			mm2p_pkg::ST_ISSUE: begin
				if (slot_q == 4'hF) state_d = mm2p_pkg::ST_DRAIN;
			end
			mm2p_pkg::ST_DRAIN: begin
				if (last_res) state_d = mm2p_pkg::ST_COMMIT;
			end
			mm2p_pkg::ST_COMMIT: begin
				state_d = last_bit ? mm2p_pkg::ST_DONE : mm2p_pkg::ST_ISSUE;
			end
			mm2p_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) state_d = mm2p_pkg::ST_IDLE;
			end
			default: state_d = mm2p_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready = (state_q == mm2p_pkg::ST_IDLE);
		issue    = (state_q == mm2p_pkg::ST_ISSUE);
		out_load = (state_q == mm2p_pkg::ST_DONE) && (!m_tvalid_q || m_tready);
	end

	// Tag the product issued this cycle
	always_comb begin
		tag_in.vld  = issue;
		tag_in.sq   = slot_q[3];
		tag_in.ent  = slot_q[2:1];
		tag_in.term = slot_q[0];
	end

	// Pick operands: left matrix is the result or the base, right is the base
	always_comb begin
		xm = slot_q[3] ? base_q : acc_q;
		unique case (slot_q[2:0])
			3'd0: begin op_x = xm.a; op_y = base_q.a; end
			3'd1: begin op_x = xm.b; op_y = base_q.c; end
			3'd2: begin op_x = xm.a; op_y = base_q.b; end
			3'd3: begin op_x = xm.b; op_y = base_q.d; end
			3'd4: begin op_x = xm.c; op_y = base_q.a; end
			3'd5: begin op_x = xm.d; op_y = base_q.c; end
			3'd6: begin op_x = xm.c; op_y = base_q.b; end
			3'd7: begin op_x = xm.d; op_y = base_q.d; end
			default: begin op_x = xm.a; op_y = base_q.a; end
		endcase
	end

	mm2p_mulred u_mulred (
		.clk     (clk),
		.arst_n  (arst_n),
		.x       (op_x),
		.y       (op_y),
		.tag_in  (tag_in),
		.res     (res),
		.tag_out (tag_out)
	);

	// Sum of the two products of one entry
	assign pair_sum = mm2p_pkg::mod_add(hold_q, res);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mm2p_pkg::ST_IDLE;
			slot_q     <= '0;
			bit_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				slot_q <= '0;
				bit_q  <= '0;
			end else if (issue) begin
				slot_q <= slot_q + 4'd1;
			end else if (state_q == mm2p_pkg::ST_COMMIT) begin
				slot_q <= '0;
				if (!last_bit) bit_q <= bit_q + CW'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Load the word, collect products and commit each bit
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q.a <= mm2p_pkg::mod_add(s_tdata[29:0], '0);
			base_q.b <= mm2p_pkg::mod_add(s_tdata[59:30], '0);
			base_q.c <= mm2p_pkg::mod_add(s_tdata[89:60], '0);
			base_q.d <= mm2p_pkg::mod_add(s_tdata[119:90], '0);
			acc_q.a  <= 30'd1;
			acc_q.b  <= '0;
			acc_q.c  <= '0;
			acc_q.d  <= 30'd1;
			pow_q    <= EXP_BITS'(s_tdata[151:120]);
		end else if (state_q == mm2p_pkg::ST_COMMIT) begin
			base_q <= nbase_q;
			if (pow_q[0]) acc_q <= nacc_q;
			pow_q <= pow_q >> 1;
		end

		if (tag_out.vld && !tag_out.term) begin
			hold_q <= res;
		end

		if (tag_out.vld && tag_out.term) begin
			if (tag_out.sq) begin
				case (tag_out.ent)
					2'd0:    nbase_q.a <= pair_sum;
					2'd1:    nbase_q.b <= pair_sum;
					2'd2:    nbase_q.c <= pair_sum;
					default: nbase_q.d <= pair_sum;
				endcase
			end else begin
				case (tag_out.ent)
					2'd0:    nacc_q.a <= pair_sum;
					2'd1:    nacc_q.b <= pair_sum;
					2'd2:    nacc_q.c <= pair_sum;
					default: nacc_q.d <= pair_sum;
				endcase
			end
		end

		if (out_load) begin
			out_q <= {acc_q.d, acc_q.c, acc_q.b, acc_q.a};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

`ifndef SYNTHESIS
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mm2p_pkg::ST_COMMIT) |-> !tag_out.vld)
		else $error("commit while products still in flight");

	a_res_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		tag_out.vld |-> (state_q == mm2p_pkg::ST_ISSUE || state_q == mm2p_pkg::ST_DRAIN))
		else $error("product arrived outside a pass");

	a_out_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[29:0] < mm2p_pkg::MOD_P && m_tdata[59:30] < mm2p_pkg::MOD_P
			&& m_tdata[89:60] < mm2p_pkg::MOD_P && m_tdata[119:90] < mm2p_pkg::MOD_P))
		else $error("result entry not reduced");
`endif

endmodule

### design/mm2p_mulred.sv
// Five-stage modular multiplier: res = x * y mod P, one product per cycle
module mm2p_mulred (
	input  logic                clk,
	input  logic                arst_n,
	input  mm2p_pkg::elem_t     x,
	input  mm2p_pkg::elem_t     y,
	input  mm2p_pkg::op_tag_t   tag_in,
	output mm2p_pkg::elem_t     res,
	output mm2p_pkg::op_tag_t   tag_out
);

	localparam logic [31:0] P32   = 32'(mm2p_pkg::MOD_P);
	localparam logic [31:0] P2_32 = P32 << 1;
	localparam logic [31:0] P3_32 = P32 + P2_32;

	mm2p_pkg::op_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	logic [59:0] prod_c;
	logic [59:0] p_s1;
	logic [61:0] t_s2;
	logic [31:0] plo_s2;
	logic [30:0] q_c;
	logic [31:0] qp_c;
	logic [31:0] qp_s3;
	logic [31:0] plo_s3;
	logic [31:0] d_s4;
	mm2p_pkg::elem_t r_c;
	mm2p_pkg::elem_t r_s5;

	// Full product of two entries
	assign prod_c = {30'd0, x} * {30'd0, y};

	// Quotient estimate from the top of the product
	assign q_c  = t_s2[61:31];
	assign qp_c = {1'b0, q_c} * P32;

	// Final fold: remainder estimate lies below 3P
	always_comb begin
		if (d_s4 >= P2_32) begin
			r_c = 30'(d_s4 - P2_32);
		end else if (d_s4 >= P32) begin
			r_c = 30'(d_s4 - P32);
		end else begin
			r_c = d_s4[29:0];
		end
	end

	// Advance tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	// Advance data through multiply, Barrett estimate and correction
	always_ff @(posedge clk) begin
		p_s1   <= prod_c;
		t_s2   <= {31'd0, p_s1[59:29]} * {31'd0, mm2p_pkg::BARRETT_MU};
		plo_s2 <= p_s1[31:0];
		qp_s3  <= qp_c;
		plo_s3 <= plo_s2;
		d_s4   <= plo_s3 - qp_s3;
		r_s5   <= r_c;
	end

	assign res     = r_s5;
	assign tag_out = tag_s5;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		tag_in.vld |-> ##5 tag_out.vld)
		else $error("product lost in multiply-reduce pipe");

	a_barrett_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s4.vld |-> (d_s4 < P3_32))
		else $error("Barrett remainder estimate out of range");

	a_res_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		tag_out.vld |-> (res < mm2p_pkg::MOD_P))
		else $error("product not fully reduced");
`endif

endmodule
